/* hdl/cvs_pkg.sv */
// ----------------------------------------------------------------------------
// cvs_pkg
// Shared types and constants for the conduction velocity stencil core.
// ----------------------------------------------------------------------------
package cvs_pkg;

	localparam int GRID_MAX_DEF = 128;

	localparam logic       ACT_LOAD    = 1'b0;
	localparam logic       ACT_COMPUTE = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SAT     = 2'd1;
	localparam logic [1:0] ST_OUTSIDE = 2'd2;

	localparam logic [1:0] REG_ROWS = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;
	localparam logic [1:0] REG_SPX  = 2'd2;
	localparam logic [1:0] REG_SPY  = 2'd3;

	localparam logic [31:0] VMAX = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_RDW,
		S_DIV,
		S_DIVW,
		S_MUL,
		S_ADD,
		S_SQW,
		S_DONE
	} state_t;

	typedef enum logic {
		M_DIV,
		M_SQRT
	} iter_mode_t;

	typedef struct packed {
		logic       start;
		iter_mode_t mode;
	} iter_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_stat_t;

endpackage

/* hdl/cvs_ram.sv */
// ----------------------------------------------------------------------------
// cvs_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module cvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* hdl/cvs_iter.sv */
// ----------------------------------------------------------------------------
// cvs_iter
// Shared compare-subtract unit: 32-step restoring divide or integer sqrt.
// ----------------------------------------------------------------------------
module cvs_iter (
	input  logic               clk,
	input  logic               arst_n,
	input  cvs_pkg::iter_cmd_t cmd,
	input  logic [16:0]        num,
	input  logic [31:0]        den,
	input  logic [63:0]        rad,
	output cvs_pkg::iter_stat_t stat,
	output logic [31:0]        result
);

	logic               busy_q;
	logic               done_q;
	logic [4:0]         cnt_q;
	cvs_pkg::iter_mode_t mode_q;
	logic [35:0]        rem_q;
	logic [31:0]        quo_q;
	logic [63:0]        rad_q;
	logic [31:0]        den_q;

	logic [35:0] trial_a;
	logic [35:0] trial_b;
	logic [36:0] diff;
	logic        take;

	always_comb begin
		if (mode_q == cvs_pkg::M_DIV) begin
			trial_a = {rem_q[34:0], 1'b0};
			trial_b = {4'b0, den_q};
		end else begin
			trial_a = {rem_q[33:0], rad_q[63:62]};
			trial_b = {2'b0, quo_q, 2'b01};
		end
		diff = {1'b0, trial_a} - {1'b0, trial_b};
		take = !diff[36];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= cmd.mode;
			rem_q  <= (cmd.mode == cvs_pkg::M_DIV) ? {19'b0, num} : '0;
			quo_q  <= '0;
			rad_q  <= rad;
			den_q  <= den;
		end else if (busy_q) begin
			rem_q <= take ? diff[35:0] : trial_a;
			quo_q <= {quo_q[30:0], take};
			rad_q <= {rad_q[61:0], 2'b00};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = quo_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("iter done without a running operation");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("iter started while busy");
	a_keeps_running: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q != 5'd31 && !cmd.start) |=> busy_q)
		else $error("iter stopped early");

endmodule

/* hdl/conduction_velocity_stencil_core.sv */
// ----------------------------------------------------------------------------
// conduction_velocity_stencil_core
// Activation-time grid with finite-difference conduction velocity readout.
// ----------------------------------------------------------------------------
// Load transfer: written if in the grid; next item accepted in the following cycle.
// Compute transfer: four neighbor reads, two divides and a sum plus sqrt on the
// shared iter unit, squaring of both components, then the output load, which waits
// for out_ready if a result is held; outside-grid or saturating cells finish early.
// One item at a time; the next transfer is taken in the cycle after the result loads.
// Reset initialises control and config; the grid RAM is not cleared (load before read).
// ----------------------------------------------------------------------------
module conduction_velocity_stencil_core #(
	parameter int GRID_MAX = cvs_pkg::GRID_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [6:0]  row,
	input  logic [6:0]  col,
	input  logic [31:0] activation_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  out_row,
	output logic [6:0]  out_col,
	output logic [31:0] velocity,
	output logic [1:0]  status
);

	localparam int DEPTH = GRID_MAX * GRID_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = $clog2(GRID_MAX + 1);

	// config
	logic [7:0]  rows_q, cols_q;
	logic [15:0] spx_q, spy_q;
	logic        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 8'd128;
			cols_q <= 8'd128;
			spx_q  <= 16'd100;
			spy_q  <= 16'd100;
		end else if (cfg_we) begin
			case (paddr[3:2])
				cvs_pkg::REG_ROWS: rows_q <= pwdata[7:0];
				cvs_pkg::REG_COLS: cols_q <= pwdata[7:0];
				cvs_pkg::REG_SPX:  spx_q  <= pwdata[15:0];
				cvs_pkg::REG_SPY:  spy_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			cvs_pkg::REG_ROWS: prdata = {24'b0, rows_q};
			cvs_pkg::REG_COLS: prdata = {24'b0, cols_q};
			cvs_pkg::REG_SPX:  prdata = {16'b0, spx_q};
			cvs_pkg::REG_SPY:  prdata = {16'b0, spy_q};
			default:           prdata = '0;
		endcase
	end

	// effective grid size, clamped to [2, GRID_MAX]
	logic [DW-1:0] rows_eff, cols_eff;

	always_comb begin
		if (rows_q < 8'd2)
			rows_eff = DW'(2);
		else if (32'(rows_q) > 32'(GRID_MAX))
			rows_eff = DW'(GRID_MAX);
		else
			rows_eff = DW'(rows_q);
		if (cols_q < 8'd2)
			cols_eff = DW'(2);
		else if (32'(cols_q) > 32'(GRID_MAX))
			cols_eff = DW'(GRID_MAX);
		else
			cols_eff = DW'(cols_q);
	end

	// input decode
	logic          in_grid;
	logic          r_first, r_last, c_first, c_last;
	logic [AW-1:0] base, stride;
	logic          accept;

	always_comb begin
		in_grid = (32'(row) < 32'(rows_eff)) && (32'(col) < 32'(cols_eff));
		r_first = (row == 7'd0);
		c_first = (col == 7'd0);
		r_last  = (32'(row) == 32'(rows_eff) - 32'd1);
		c_last  = (32'(col) == 32'(cols_eff) - 32'd1);
		base    = AW'(32'(row) * 32'(cols_eff) + 32'(col));
		stride  = AW'(cols_eff);
	end

	// sequencer
	cvs_pkg::state_t state_q, state_d;
	logic [AW-1:0]   addr_q [4];
	logic [31:0]     t_q [4];
	logic [1:0]      idx_q;
	logic            phase_q;
	logic [6:0]      row_q, col_q;
	logic [16:0]     span_x_q, span_y_q;
	logic [31:0]     vx_q, vy_q;
	logic [63:0]     sq_x_q, sq_y_q;
	logic [31:0]     res_vel_q;
	logic [1:0]      res_st_q;
	logic            out_valid_q;
	logic [6:0]      out_row_q, out_col_q;
	logic [31:0]     out_vel_q;
	logic [1:0]      out_st_q;

	logic [31:0] pair_a, pair_b, adiff;
	logic [16:0] span;
	logic        div_sat;
	logic [31:0] mul_in;
	logic [63:0] mul_p;
	logic [64:0] sum;
	logic        ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_rdata;
	logic        out_load;

	cvs_pkg::iter_cmd_t  iter_cmd;
	cvs_pkg::iter_stat_t iter_stat;
	logic [31:0]         iter_res;

	assign in_ready = (state_q == cvs_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;
	assign ram_we   = accept && (action == cvs_pkg::ACT_LOAD) && in_grid;
	assign ram_addr = (state_q == cvs_pkg::S_IDLE) ? base : addr_q[idx_q];

	always_comb begin
		pair_a  = phase_q ? t_q[2] : t_q[0];
		pair_b  = phase_q ? t_q[3] : t_q[1];
		adiff   = (pair_a > pair_b) ? pair_a - pair_b : pair_b - pair_a;
		span    = phase_q ? span_y_q : span_x_q;
		// zero difference or quotient beyond 32 bits
		div_sat = (adiff == 32'd0) || (32'(span) >= adiff);
		mul_in  = phase_q ? vy_q : vx_q;
		mul_p   = {32'b0, mul_in} * {32'b0, mul_in};
		sum     = {1'b0, sq_x_q} + {1'b0, sq_y_q};
	end

	always_comb begin
		state_d       = state_q;
		iter_cmd.start = 1'b0;
		iter_cmd.mode  = cvs_pkg::M_DIV;
		out_load      = 1'b0;
		case (state_q)
			cvs_pkg::S_IDLE: begin
				if (accept && action == cvs_pkg::ACT_COMPUTE)
					state_d = in_grid ? cvs_pkg::S_RD : cvs_pkg::S_DONE;
			end
			cvs_pkg::S_RD: state_d = cvs_pkg::S_RDW;
			cvs_pkg::S_RDW: begin
				state_d = (idx_q == 2'd3) ? cvs_pkg::S_DIV : cvs_pkg::S_RD;
			end
			cvs_pkg::S_DIV: begin
				if (div_sat) begin
					state_d = cvs_pkg::S_DONE;
				end else begin
					iter_cmd.start = 1'b1;
					state_d = cvs_pkg::S_DIVW;
				end
			end
			cvs_pkg::S_DIVW: begin
				if (iter_stat.done)
					state_d = phase_q ? cvs_pkg::S_MUL : cvs_pkg::S_DIV;
			end
			cvs_pkg::S_MUL: begin
				if (phase_q) state_d = cvs_pkg::S_ADD;
			end
			cvs_pkg::S_ADD: begin
				if (sum[64]) begin
					state_d = cvs_pkg::S_DONE;
				end else begin
					iter_cmd.start = 1'b1;
					iter_cmd.mode  = cvs_pkg::M_SQRT;
					state_d = cvs_pkg::S_SQW;
				end
			end
			cvs_pkg::S_SQW: begin
				if (iter_stat.done) state_d = cvs_pkg::S_DONE;
			end
			cvs_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = cvs_pkg::S_IDLE;
				end
			end
			default: state_d = cvs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cvs_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			phase_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (accept) begin
				idx_q   <= '0;
				phase_q <= 1'b0;
			end else if (state_q == cvs_pkg::S_RDW) begin
				idx_q <= idx_q + 2'd1;
			end else if (state_q == cvs_pkg::S_DIVW && iter_stat.done) begin
				phase_q <= !phase_q;
			end else if (state_q == cvs_pkg::S_MUL) begin
				phase_q <= !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q     <= row;
			col_q     <= col;
			// x pair: forward on first row, backward on last, central inside
			addr_q[0] <= r_first ? base + stride : (r_last ? base : base - stride);
			addr_q[1] <= r_first ? base : (r_last ? base - stride : base + stride);
			addr_q[2] <= c_first ? base + AW'(1) : (c_last ? base : base - AW'(1));
			addr_q[3] <= c_first ? base : (c_last ? base - AW'(1) : base + AW'(1));
			span_x_q  <= (r_first || r_last) ? {1'b0, spx_q} : {spx_q, 1'b0};
			span_y_q  <= (c_first || c_last) ? {1'b0, spy_q} : {spy_q, 1'b0};
			res_vel_q <= '0;
			res_st_q  <= cvs_pkg::ST_OUTSIDE;
		end
		if (state_q == cvs_pkg::S_RDW)
			t_q[idx_q] <= ram_rdata;
		if ((state_q == cvs_pkg::S_DIV && div_sat) ||
		    (state_q == cvs_pkg::S_ADD && sum[64])) begin
			res_vel_q <= cvs_pkg::VMAX;
			res_st_q  <= cvs_pkg::ST_SAT;
		end
		if (state_q == cvs_pkg::S_DIVW && iter_stat.done) begin
			if (phase_q) vy_q <= iter_res;
			else         vx_q <= iter_res;
		end
		if (state_q == cvs_pkg::S_MUL) begin
			if (phase_q) sq_y_q <= mul_p;
			else         sq_x_q <= mul_p;
		end
		if (state_q == cvs_pkg::S_SQW && iter_stat.done) begin
			res_vel_q <= iter_res;
			res_st_q  <= cvs_pkg::ST_OK;
		end
		if (out_load) begin
			out_row_q <= row_q;
			out_col_q <= col_q;
			out_vel_q <= res_vel_q;
			out_st_q  <= res_st_q;
		end
	end

	cvs_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (activation_time),
		.rdata (ram_rdata)
	);

	cvs_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (iter_cmd),
		.num    (span),
		.den    (adiff),
		.rad    (sum[63:0]),
		.stat   (iter_stat),
		.result (iter_res)
	);

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign velocity  = out_vel_q;
	assign status    = out_st_q;

	a_idle_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cvs_pkg::S_IDLE) |-> !iter_stat.busy)
		else $error("iter unit busy while sequencer idle");
	a_write_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == cvs_pkg::S_IDLE && in_valid))
		else $error("grid write outside a load transfer");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == cvs_pkg::S_DONE))
		else $error("result raised without finishing a compute");
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_st_q == cvs_pkg::ST_OUTSIDE) |-> (out_vel_q == 32'd0))
		else $error("outside-grid result with nonzero velocity");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// conduction_velocity_stencil_core testbench
// Loads activation times into the grid and requests conduction velocity at
// cells over several grid sizes and spacings. Every result is checked, against
// an in-bench finite-difference predictor or a typed expectation in the directed
// list; random stalls and gaps on both streams exercise the handshakes.
// ----------------------------------------------------------------------------
module testbench;

	localparam int STORE_DEPTH = cvs_pkg::GRID_MAX_DEF * cvs_pkg::GRID_MAX_DEF;

	typedef struct {
		logic [6:0]  row;
		logic [6:0]  col;
		logic [31:0] vel;
		logic [1:0]  st;
	} cv_result_t;

	typedef struct {
		logic        act;
		int          r;
		int          c;
		logic [31:0] t;
		bit          typed;
		logic [31:0] vel;
		logic [1:0]  st;
	} stim_row_t;

	logic        clk = 0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic        action;
	logic [6:0]  row, col;
	logic [31:0] activation_time;
	logic        out_valid, out_ready;
	logic [6:0]  out_row, out_col;
	logic [31:0] velocity;
	logic [1:0]  status;

	conduction_velocity_stencil_core dut (.*);

	always #1 clk = ~clk;

	// predictor state
	logic [31:0] time_mem [STORE_DEPTH];
	bit          loaded [STORE_DEPTH];
	logic [7:0]  cfg_rows = 8'd128, cfg_cols = 8'd128;
	logic [15:0] cfg_spx = 16'd100, cfg_spy = 16'd100;

	cv_result_t  pending_cv[$];
	int          errors = 0, n_loads = 0, n_computes = 0, n_checked = 0;
	int          n_sat = 0, n_outside = 0;
	bit          quiet = 0, hold_req = 0;
	logic [31:0] last_t = 0;

	function automatic int clamp_dim(logic [7:0] v);
		if (v < 2) return 2;
		if (v > cvs_pkg::GRID_MAX_DEF) return cvs_pkg::GRID_MAX_DEF;
		return int'(v);
	endfunction

	function automatic logic [31:0] floor_sqrt(logic [63:0] n);
		logic [63:0] res, trial;
		res = 0;
		for (int i = 31; i >= 0; i--) begin
			trial = res | (64'd1 << i);
			if (trial * trial <= n) res = trial;
		end
		return res[31:0];
	endfunction

	function automatic logic [63:0] slope(logic [16:0] span, logic [31:0] a, logic [31:0] b,
			inout bit zero);
		logic [63:0] d, num;
		d = (a > b) ? {32'd0, a - b} : {32'd0, b - a};
		if (d == 0) begin
			zero = 1;
			return 64'd0;
		end
		num = {15'd0, span, 32'd0};
		return num / d;
	endfunction

	function automatic logic [31:0] cell_time(int r, int c, int cols);
		return time_mem[r * cols + c];
	endfunction

	function automatic cv_result_t predict_velocity(int r, int c);
		cv_result_t res;
		int rows, cols;
		bit zero;
		logic [63:0] vx, vy, sx, sy;
		logic [64:0] sum;
		rows = clamp_dim(cfg_rows);
		cols = clamp_dim(cfg_cols);
		zero = 0;
		res.row = 7'(r);
		res.col = 7'(c);
		if (r >= rows || c >= cols) begin
			res.vel = '0;
			res.st = cvs_pkg::ST_OUTSIDE;
			return res;
		end
		if (r == 0)
			vx = slope({1'b0, cfg_spx}, cell_time(1, c, cols), cell_time(0, c, cols), zero);
		else if (r == rows - 1)
			vx = slope({1'b0, cfg_spx}, cell_time(r, c, cols), cell_time(r - 1, c, cols),
				zero);
		else
			vx = slope({cfg_spx, 1'b0}, cell_time(r - 1, c, cols), cell_time(r + 1, c, cols),
				zero);
		if (c == 0)
			vy = slope({1'b0, cfg_spy}, cell_time(r, 1, cols), cell_time(r, 0, cols), zero);
		else if (c == cols - 1)
			vy = slope({1'b0, cfg_spy}, cell_time(r, c, cols), cell_time(r, c - 1, cols),
				zero);
		else
			vy = slope({cfg_spy, 1'b0}, cell_time(r, c - 1, cols), cell_time(r, c + 1, cols),
				zero);
		if (zero || vx > cvs_pkg::VMAX || vy > cvs_pkg::VMAX) begin
			res.vel = cvs_pkg::VMAX;
			res.st = cvs_pkg::ST_SAT;
			return res;
		end
		sx = vx * vx;
		sy = vy * vy;
		sum = {1'b0, sx} + {1'b0, sy};
		if (sum[64]) begin
			res.vel = cvs_pkg::VMAX;
			res.st = cvs_pkg::ST_SAT;
			return res;
		end
		res.vel = floor_sqrt(sum[63:0]);
		res.st = cvs_pkg::ST_OK;
		return res;
	endfunction

	task automatic apb_write(logic [1:0] idx, logic [31:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			cvs_pkg::REG_ROWS: cfg_rows = value[7:0];
			cvs_pkg::REG_COLS: cfg_cols = value[7:0];
			cvs_pkg::REG_SPX:  cfg_spx = value[15:0];
			default:           cfg_spy = value[15:0];
		endcase
	endtask

	task automatic drain();
		while (pending_cv.size() != 0) @(posedge clk);
	endtask

	task automatic configure(logic [7:0] r, logic [7:0] c, logic [15:0] sx, logic [15:0] sy);
		drain();
		repeat (8) @(posedge clk);
		apb_write(cvs_pkg::REG_ROWS, 32'(r));
		apb_write(cvs_pkg::REG_COLS, 32'(c));
		apb_write(cvs_pkg::REG_SPX, 32'(sx));
		apb_write(cvs_pkg::REG_SPY, 32'(sy));
	endtask

	task automatic idle_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// one transfer on the input stream, then update the predictor
	task automatic send_item(logic act, int r, int c, logic [31:0] t, bit typed,
			cv_result_t typed_res);
		int cols;
		idle_gap();
		in_valid <= 1;
		action <= act;
		row <= 7'(r);
		col <= 7'(c);
		activation_time <= t;
		do @(posedge clk); while (!in_ready);
		cols = clamp_dim(cfg_cols);
		if (act == cvs_pkg::ACT_LOAD) begin
			n_loads++;
			if (r < clamp_dim(cfg_rows) && c < cols) begin
				time_mem[r * cols + c] = t;
				loaded[r * cols + c] = 1;
			end
		end else begin
			n_computes++;
			pending_cv.push_back(typed ? typed_res : predict_velocity(r, c));
		end
	endtask

	function automatic logic [31:0] pick_time();
		case ($urandom_range(0, 9))
			0, 1: return last_t + $urandom_range(0, 2);
			2, 3: return last_t + ($urandom_range(1, 400) << 12);
			4:    return last_t - ($urandom_range(1, 60) << 16);
			default: return $urandom;
		endcase
	endfunction

	task automatic load_cell(int r, int c, bit force_load);
		cv_result_t none;
		logic [31:0] t;
		if (force_load || !loaded[r * clamp_dim(cfg_cols) + c] || $urandom_range(0, 2) == 0) begin
			t = pick_time();
			last_t = t;
			send_item(cvs_pkg::ACT_LOAD, r, c, t, 0, none);
		end
	endtask

	// load whatever neighbors are missing (and some at random), then ask for the velocity
	task automatic stencil_sequence();
		cv_result_t none;
		int rows, cols, r, c, xa, xb, ya, yb;
		rows = clamp_dim(cfg_rows);
		cols = clamp_dim(cfg_cols);
		r = $urandom_range(0, rows - 1);
		c = $urandom_range(0, cols - 1);
		if ($urandom_range(0, 9) == 0) begin
			r = $urandom_range(0, 127);
			c = $urandom_range(0, 127);
		end
		if (r < rows && c < cols) begin
			xa = (r == 0) ? 1 : r - 1;
			xb = (r == 0) ? 0 : ((r == rows - 1) ? r : r + 1);
			ya = (c == 0) ? 1 : c - 1;
			yb = (c == 0) ? 0 : ((c == cols - 1) ? c : c + 1);
			load_cell(xa, c, 0);
			load_cell(xb, c, 0);
			load_cell(r, ya, 0);
			load_cell(r, yb, 0);
		end
		send_item(cvs_pkg::ACT_COMPUTE, r, c, $urandom, 0, none);
	endtask

	task automatic random_phase(int n_seq);
		cv_result_t none;
		for (int i = 0; i < n_seq; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_item(cvs_pkg::ACT_LOAD, $urandom_range(0, 127), $urandom_range(0, 127),
					$urandom, 0, none);
			else
				stencil_sequence();
			if (i == n_seq / 2 && $urandom_range(0, 1) == 0) begin
				// drop valid so the last transfer is not offered again
				in_valid <= 0;
				drain();
			end
		end
	endtask

	// receiver: short random stalls, one long hold-off on request
	initial begin
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 3) - 1) @(posedge clk);
			end else begin
				out_ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		cv_result_t exp_cv;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cv.size() == 0) begin
				$display("%0t: unexpected result row %0d col %0d", $time, out_row, out_col);
				errors++;
			end else begin
				exp_cv = pending_cv.pop_front();
				n_checked++;
				if (exp_cv.st == cvs_pkg::ST_SAT) n_sat++;
				if (exp_cv.st == cvs_pkg::ST_OUTSIDE) n_outside++;
				if (out_row !== exp_cv.row || out_col !== exp_cv.col ||
						velocity !== exp_cv.vel || status !== exp_cv.st) begin
					$display("%0t: expected row %0d col %0d vel %h st %0d, got row %0d col %0d vel %h st %0d",
						$time, exp_cv.row, exp_cv.col, exp_cv.vel, exp_cv.st,
						out_row, out_col, velocity, status);
					errors++;
				end
			end
		end
	end

	initial begin
		#4000000;
		$display("conduction_velocity_stencil_core: mismatch");
		$finish;
	end

	initial begin
		stim_row_t dir [$];
		cv_result_t typed_res;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		in_valid = 0;
		action = cvs_pkg::ACT_LOAD;
		row = 0;
		col = 0;
		activation_time = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		configure(8'd4, 8'd4, 16'd100, 16'd100);
		dir = '{
			'{cvs_pkg::ACT_LOAD, 0, 0, 32'h0, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_LOAD, 1, 0, 32'h10000, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_LOAD, 0, 1, 32'h20000, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_COMPUTE, 0, 0, 32'h0, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_LOAD, 3, 3, 32'h7, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_LOAD, 2, 3, 32'h7, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_LOAD, 3, 2, 32'hFFFFFFFF, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_COMPUTE, 3, 3, 32'h0, 1, cvs_pkg::VMAX, cvs_pkg::ST_SAT},
			'{cvs_pkg::ACT_COMPUTE, 5, 1, 32'hFFFFFFFF, 1, 32'h0, cvs_pkg::ST_OUTSIDE},
			'{cvs_pkg::ACT_COMPUTE, 127, 127, 32'h0, 1, 32'h0, cvs_pkg::ST_OUTSIDE},
			'{cvs_pkg::ACT_LOAD, 127, 127, 32'hFFFFFFFF, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_LOAD, 1, 1, 32'h10000, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_LOAD, 2, 1, 32'h10001, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_LOAD, 1, 2, 32'h10001, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_COMPUTE, 1, 1, 32'h0, 1, cvs_pkg::VMAX, cvs_pkg::ST_SAT},
			'{cvs_pkg::ACT_LOAD, 3, 0, 32'h50000, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_LOAD, 2, 0, 32'h30000, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_LOAD, 3, 1, 32'h58000, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_COMPUTE, 3, 0, 32'h0, 0, 0, cvs_pkg::ST_OK},
			'{cvs_pkg::ACT_COMPUTE, 2, 3, 32'h0, 1, 32'h0, cvs_pkg::ST_OUTSIDE}
		};
		foreach (dir[i]) begin
			typed_res.row = 7'(dir[i].r);
			typed_res.col = 7'(dir[i].c);
			typed_res.vel = dir[i].vel;
			typed_res.st = dir[i].st;
			// shrink to two rows so the last request, at row 2, falls outside the grid
			if (i == 19) begin
				in_valid <= 0;
				configure(8'd2, 8'd4, 16'd100, 16'd100);
			end
			send_item(dir[i].act, dir[i].r, dir[i].c, dir[i].t, dir[i].typed, typed_res);
		end
		in_valid <= 0;

		configure(8'd2, 8'd2, 16'd1, 16'd1);
		random_phase(40);
		in_valid <= 0;
		configure(8'd0, 8'd1, 16'hFFFF, 16'hFFFF);
		random_phase(40);
		in_valid <= 0;
		configure(8'd128, 8'd128, 16'd100, 16'd100);
		hold_req = 1;
		random_phase(50);
		in_valid <= 0;
		configure(8'd255, 8'd255, 16'($urandom_range(1, 65535)),
			16'($urandom_range(1, 65535)));
		random_phase(40);
		in_valid <= 0;
		configure(8'd5, 8'd9, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
		random_phase(50);
		in_valid <= 0;
		configure(8'd16, 8'd3, 16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)));
		random_phase(50);
		in_valid <= 0;
		configure(8'd200, 8'd7, 16'd0, 16'($urandom_range(1, 65535)));
		random_phase(40);
		in_valid <= 0;
		configure(8'd8, 8'd8, 16'($urandom), 16'($urandom));
		quiet = 1;
		random_phase(50);
		in_valid <= 0;

		drain();
		repeat (150) @(posedge clk);
		$display("Covered %0d loads and %0d velocity requests over ten grid settings;",
			n_loads, n_computes);
		$display("checked %0d results, %0d saturated, %0d outside the grid.",
			n_checked, n_sat, n_outside);
		if (errors == 0 && pending_cv.size() == 0)
			$display("conduction_velocity_stencil_core: match");
		else
			$display("conduction_velocity_stencil_core: mismatch");
		$finish;
	end
endmodule

/* sim.f */
hdl/cvs_pkg.sv
hdl/cvs_ram.sv
hdl/cvs_iter.sv
hdl/conduction_velocity_stencil_core.sv
dv/testbench.sv
